// ===== hw/rtl/spi_flash_command_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// spi flash command sequencer assertion macros
// shared helpers for the concurrent checks of the sequencer
// ----------------------------------------------------------------------------
`ifndef SPI_FLASH_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SFC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sfc same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sfc next-cycle check failed");

`endif

// ===== hw/rtl/sfc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfc_pkg
// types and constants of the spi flash command sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

	// field widths
	localparam int OP_W         = 3;
	localparam int ADDR_FIELD_W = 24;
	localparam int CNT_W        = 25;
	localparam int BYTE_W       = 8;
	localparam int HDR_W        = 2;

	// configuration port
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-1:0] REG_DEVICE_KIND = 2'd0;

	// item kinds
	localparam logic MODE_CMD  = 1'b0;
	localparam logic MODE_XCHG = 1'b1;

	// host operations
	localparam logic [OP_W-1:0] OP_READ   = 3'd0;
	localparam logic [OP_W-1:0] OP_PROG   = 3'd1;
	localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
	localparam logic [OP_W-1:0] OP_UNLOCK = 3'd3;
	localparam logic [OP_W-1:0] OP_RESET  = 3'd4;

	// device kinds
	localparam logic KIND_BASIC = 1'b0;
	localparam logic KIND_EXT   = 1'b1;

	// flash opcodes
	localparam logic [BYTE_W-1:0] FL_READ     = 8'h03;
	localparam logic [BYTE_W-1:0] FL_WREN     = 8'h06;
	localparam logic [BYTE_W-1:0] FL_WRDI     = 8'h04;
	localparam logic [BYTE_W-1:0] FL_RDSR     = 8'h05;
	localparam logic [BYTE_W-1:0] FL_PP       = 8'h02;
	localparam logic [BYTE_W-1:0] FL_SE_BIG   = 8'hD8;
	localparam logic [BYTE_W-1:0] FL_SE_SMALL = 8'h20;
	localparam logic [BYTE_W-1:0] FL_UNLOCK   = 8'h98;
	localparam logic [BYTE_W-1:0] FL_RSTEN    = 8'h66;
	localparam logic [BYTE_W-1:0] FL_RST      = 8'h99;
	localparam logic [BYTE_W-1:0] FL_DUMMY    = 8'h00;
	localparam logic [BYTE_W-1:0] SR_WIP_MASK = 8'h01;

	// header positions
	localparam logic [HDR_W-1:0] HDR_HI  = 2'd0;
	localparam logic [HDR_W-1:0] HDR_MID = 2'd1;
	localparam logic [HDR_W-1:0] HDR_LO  = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_WREN  = 4'd1,
		PH_OPC   = 4'd2,
		PH_ADDR  = 4'd3,
		PH_RDATA = 4'd4,
		PH_WDATA = 4'd5,
		PH_POLLC = 4'd6,
		PH_POLLS = 4'd7,
		PH_WRDI  = 4'd8,
		PH_UNLK  = 4'd9,
		PH_RST1  = 4'd10,
		PH_RST2  = 4'd11
	} phase_t;

	typedef struct packed {
		logic                    mode;
		logic [OP_W-1:0]         op;
		logic [ADDR_FIELD_W-1:0] address;
		logic [CNT_W-1:0]        byte_count;
		logic [BYTE_W-1:0]       rx_byte;
		logic [BYTE_W-1:0]       wr_data;
	} sfc_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0] tx_byte;
		logic              tx_valid;
		logic              frame_last;
		logic              rd_valid;
		logic [BYTE_W-1:0] rd_data;
		logic              wr_take;
		logic              op_done;
		logic              busy_res;
	} sfc_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfc_cmd_if.sv =====
// ----------------------------------------------------------------------------
// sfc_cmd_if
// valid/ready channel carrying host commands and exchange reports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfc_cmd_if;
	import sfc_pkg::*;

	logic     valid;
	logic     ready;
	sfc_cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sfc_res_if.sv =====
// ----------------------------------------------------------------------------
// sfc_res_if
// valid/ready channel carrying sequencer results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfc_res_if;
	import sfc_pkg::*;

	logic     valid;
	logic     ready;
	sfc_res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spi_flash_command_sequencer.sv =====
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer
// byte-level spi nor flash command sequencer with apb configuration
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "spi_flash_command_sequencer_defines.svh"

// Byte-level SPI NOR command sequencer. A command transaction (mode 0) starts
// a read, program, sector erase, unlock or reset; every exchange transaction
// (mode 1) reports the byte clocked in from the flash and returns the next
// byte to shift out, with frame_last marking where chip select is released.
// Every cmd transaction yields exactly one res transaction, in the cycle after
// acceptance, from the result register. At most one transaction is taken per clock;
// cmd.ready only drops while the result register holds an untaken result and
// res.ready is low, so throughput is one transaction per cycle when the sink
// keeps up. Commands arriving while an operation runs are dropped (result
// shows only busy_res); exchanges while idle give an all-zero result.
// device_kind sits at APB offset 0 and should only be written while idle.
// There is no memory and no start-up clearing pass.

module spi_flash_command_sequencer #(
	parameter int PAGE_BYTES   = 256,
	parameter int ADDRESS_BITS = 24
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	sfc_cmd_if.sink                              cmd,
	sfc_res_if.source                            res,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [sfc_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [sfc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [sfc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                 pready
);
	import sfc_pkg::*;

	localparam int CHUNK_W = $clog2(PAGE_BYTES + 1);
	localparam int AEXT_W  = (ADDRESS_BITS > ADDR_FIELD_W) ? ADDRESS_BITS : ADDR_FIELD_W;

	// configuration
	logic device_kind_q;

	// sequencer state
	phase_t                  phase_q, phase_d;
	logic [OP_W-1:0]         current_op_q, current_op_d;
	logic [ADDRESS_BITS-1:0] flash_address_q, flash_address_d;
	logic [CNT_W-1:0]        bytes_remaining_q, bytes_remaining_d;
	logic [CHUNK_W-1:0]      chunk_remaining_q, chunk_remaining_d;
	logic [HDR_W-1:0]        header_index_q, header_index_d;

	// result register
	logic     res_valid_q;
	sfc_res_t res_q, res_d;

	logic cmd_accept;
	logic is_cmd;

	// helper terms
	logic [HDR_W-1:0]        hdr_next;
	logic                    hdr_done;
	logic [AEXT_W-1:0]       addr_ext;
	logic [BYTE_W-1:0]       addr_byte_next;
	logic [BYTE_W-1:0]       addr_byte_hi;
	logic [ADDRESS_BITS-1:0] flash_address_inc;
	logic                    bytes_zero;
	logic                    bytes_one;
	logic                    bytes_two;
	logic                    bytes_gt1;
	logic                    cnt_zero;
	logic                    chunk_zero;
	logic                    chunk_one;
	logic [CNT_W-1:0]        chunk_src;
	logic [CHUNK_W-1:0]      chunk_len;
	logic [CNT_W-1:0]        bytes_after_chunk;
	logic                    status_busy;

	// ------------------------------------------------------------------
	// apb configuration port, no wait states
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_kind_q <= KIND_BASIC;
		end else if (psel && penable && pwrite && pready && paddr == REG_DEVICE_KIND) begin
			device_kind_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_DEVICE_KIND) begin
			prdata = CFG_DATA_W'(device_kind_q);
		end
	end

	// ------------------------------------------------------------------
	// handshake: result register decouples the two sides
	// ------------------------------------------------------------------
	assign cmd.ready  = !res_valid_q || res.ready;
	assign cmd_accept = cmd.valid && cmd.ready;
	assign is_cmd     = (cmd.data.mode == MODE_CMD);

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// ------------------------------------------------------------------
	// helper terms
	// ------------------------------------------------------------------
	assign hdr_next = header_index_q + HDR_W'(1);
	assign hdr_done = (header_index_q == HDR_LO);

	// address bytes always come from bits 23..0, zero above a narrow counter
	assign addr_ext = AEXT_W'(flash_address_q);
	assign addr_byte_hi = addr_ext[23:16];

	always_comb begin
		case (hdr_next)
			HDR_MID: addr_byte_next = addr_ext[15:8];
			HDR_LO:  addr_byte_next = addr_ext[7:0];
			default: addr_byte_next = addr_ext[23:16];
		endcase
	end

	assign flash_address_inc = flash_address_q + ADDRESS_BITS'(1);

	assign bytes_zero = (bytes_remaining_q == '0);
	assign bytes_one  = (bytes_remaining_q == CNT_W'(1));
	assign bytes_two  = (bytes_remaining_q == CNT_W'(2));
	assign bytes_gt1  = (bytes_remaining_q > CNT_W'(1));
	assign cnt_zero   = (cmd.data.byte_count == '0);
	assign chunk_zero = (chunk_remaining_q == '0);
	assign chunk_one  = (chunk_remaining_q == CHUNK_W'(1));

	// page-sized slice of what is left, from the command or the running count
	assign chunk_src = is_cmd ? cmd.data.byte_count : bytes_remaining_q;
	assign chunk_len = (chunk_src > CNT_W'(PAGE_BYTES)) ? CHUNK_W'(PAGE_BYTES)
	                                                   : chunk_src[CHUNK_W-1:0];
	assign bytes_after_chunk = chunk_src - CNT_W'(chunk_len);

	assign status_busy = |(cmd.data.rx_byte & SR_WIP_MASK);

	// ------------------------------------------------------------------
	// next phase
	// ------------------------------------------------------------------
	always_comb begin
		phase_d = phase_q;
		if (is_cmd) begin
			if (phase_q == PH_IDLE) begin
				case (cmd.data.op)
					OP_READ:   phase_d = PH_OPC;
					OP_PROG:   phase_d = cnt_zero ? PH_IDLE : PH_WREN;
					OP_ERASE:  phase_d = PH_WREN;
					OP_UNLOCK: phase_d = (device_kind_q == KIND_EXT) ? PH_WREN : PH_IDLE;
					OP_RESET:  phase_d = (device_kind_q == KIND_EXT) ? PH_RST1 : PH_IDLE;
					default:   phase_d = PH_IDLE;
				endcase
			end
		end else begin
			case (phase_q)
				PH_IDLE: phase_d = PH_IDLE;
				PH_WREN: begin
					if (current_op_q == OP_PROG || current_op_q == OP_ERASE) begin
						phase_d = PH_OPC;
					end else begin
						phase_d = PH_UNLK;
					end
				end
				PH_OPC: phase_d = PH_ADDR;
				PH_ADDR: begin
					if (!hdr_done) begin
						phase_d = PH_ADDR;
					end else if (current_op_q == OP_READ) begin
						phase_d = bytes_zero ? PH_IDLE : PH_RDATA;
					end else if (current_op_q == OP_PROG) begin
						phase_d = PH_WDATA;
					end else begin
						phase_d = PH_POLLC;
					end
				end
				PH_RDATA: phase_d = bytes_gt1 ? PH_RDATA : PH_IDLE;
				PH_WDATA: phase_d = chunk_zero ? PH_POLLC : PH_WDATA;
				PH_POLLC: phase_d = PH_POLLS;
				PH_POLLS: phase_d = status_busy ? PH_POLLC : PH_WRDI;
				PH_WRDI: begin
					phase_d = (current_op_q == OP_PROG && !bytes_zero) ? PH_WREN : PH_IDLE;
				end
				PH_UNLK: phase_d = PH_POLLC;
				PH_RST1: phase_d = PH_RST2;
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// result and datapath updates
	// ------------------------------------------------------------------
	always_comb begin
		res_d             = '0;
		current_op_d      = current_op_q;
		flash_address_d   = flash_address_q;
		bytes_remaining_d = bytes_remaining_q;
		chunk_remaining_d = chunk_remaining_q;
		header_index_d    = header_index_q;

		if (is_cmd) begin
			if (phase_q == PH_IDLE) begin
				current_op_d      = cmd.data.op;
				flash_address_d   = ADDRESS_BITS'(cmd.data.address);
				bytes_remaining_d = cmd.data.byte_count;
				chunk_remaining_d = '0;
				header_index_d    = HDR_HI;
				case (cmd.data.op)
					OP_READ: begin
						res_d.tx_byte  = FL_READ;
						res_d.tx_valid = 1'b1;
					end
					OP_PROG: begin
						if (cnt_zero) begin
							res_d.op_done = 1'b1;
						end else begin
							bytes_remaining_d = bytes_after_chunk;
							chunk_remaining_d = chunk_len;
							res_d.tx_byte     = FL_WREN;
							res_d.tx_valid    = 1'b1;
							res_d.frame_last  = 1'b1;
						end
					end
					OP_ERASE: begin
						res_d.tx_byte    = FL_WREN;
						res_d.tx_valid   = 1'b1;
						res_d.frame_last = 1'b1;
					end
					OP_UNLOCK: begin
						if (device_kind_q == KIND_EXT) begin
							res_d.tx_byte    = FL_WREN;
							res_d.tx_valid   = 1'b1;
							res_d.frame_last = 1'b1;
						end else begin
							res_d.op_done = 1'b1;
						end
					end
					OP_RESET: begin
						if (device_kind_q == KIND_EXT) begin
							res_d.tx_byte    = FL_RSTEN;
							res_d.tx_valid   = 1'b1;
							res_d.frame_last = 1'b1;
						end else begin
							res_d.op_done = 1'b1;
						end
					end
					default: res_d.op_done = 1'b1;
				endcase
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
					res_d = '0;
				end
				PH_WREN: begin
					res_d.tx_valid = 1'b1;
					if (current_op_q == OP_PROG) begin
						res_d.tx_byte = FL_PP;
					end else if (current_op_q == OP_ERASE) begin
						res_d.tx_byte = (device_kind_q == KIND_BASIC) ? FL_SE_BIG : FL_SE_SMALL;
					end else begin
						res_d.tx_byte    = FL_UNLOCK;
						res_d.frame_last = 1'b1;
					end
				end
				PH_OPC: begin
					header_index_d = HDR_HI;
					res_d.tx_byte  = addr_byte_hi;
					res_d.tx_valid = 1'b1;
				end
				PH_ADDR: begin
					if (!hdr_done) begin
						// next address byte; erase and empty read end the frame here
						header_index_d   = hdr_next;
						res_d.tx_byte    = addr_byte_next;
						res_d.tx_valid   = 1'b1;
						res_d.frame_last = (hdr_next == HDR_LO) &&
						                   (current_op_q == OP_ERASE ||
						                    (current_op_q == OP_READ && bytes_zero));
					end else if (current_op_q == OP_READ) begin
						if (bytes_zero) begin
							res_d.op_done = 1'b1;
						end else begin
							res_d.tx_byte    = FL_DUMMY;
							res_d.tx_valid   = 1'b1;
							res_d.frame_last = bytes_one;
						end
					end else if (current_op_q == OP_PROG) begin
						// first data byte of the page program
						chunk_remaining_d = chunk_remaining_q - CHUNK_W'(1);
						flash_address_d   = flash_address_inc;
						res_d.wr_take     = 1'b1;
						res_d.tx_byte     = cmd.data.wr_data;
						res_d.tx_valid    = 1'b1;
						res_d.frame_last  = chunk_one;
					end else begin
						res_d.tx_byte  = FL_RDSR;
						res_d.tx_valid = 1'b1;
					end
				end
				PH_RDATA: begin
					res_d.rd_valid = 1'b1;
					res_d.rd_data  = cmd.data.rx_byte;
					if (!bytes_zero) begin
						bytes_remaining_d = bytes_remaining_q - CNT_W'(1);
					end
					if (bytes_gt1) begin
						res_d.tx_byte    = FL_DUMMY;
						res_d.tx_valid   = 1'b1;
						res_d.frame_last = bytes_two;
					end else begin
						res_d.op_done = 1'b1;
					end
				end
				PH_WDATA: begin
					if (!chunk_zero) begin
						chunk_remaining_d = chunk_remaining_q - CHUNK_W'(1);
						flash_address_d   = flash_address_inc;
						res_d.wr_take     = 1'b1;
						res_d.tx_byte     = cmd.data.wr_data;
						res_d.tx_valid    = 1'b1;
						res_d.frame_last  = chunk_one;
					end else begin
						res_d.tx_byte  = FL_RDSR;
						res_d.tx_valid = 1'b1;
					end
				end
				PH_POLLC: begin
					res_d.tx_byte    = FL_DUMMY;
					res_d.tx_valid   = 1'b1;
					res_d.frame_last = 1'b1;
				end
				PH_POLLS: begin
					// write-in-progress still set: poll again; clear: send write disable
					res_d.tx_valid = 1'b1;
					if (status_busy) begin
						res_d.tx_byte = FL_RDSR;
					end else begin
						res_d.tx_byte    = FL_WRDI;
						res_d.frame_last = 1'b1;
					end
				end
				PH_WRDI: begin
					if (current_op_q == OP_PROG && !bytes_zero) begin
						bytes_remaining_d = bytes_after_chunk;
						chunk_remaining_d = chunk_len;
						res_d.tx_byte     = FL_WREN;
						res_d.tx_valid    = 1'b1;
						res_d.frame_last  = 1'b1;
					end else begin
						res_d.op_done = 1'b1;
					end
				end
				PH_UNLK: begin
					res_d.tx_byte  = FL_RDSR;
					res_d.tx_valid = 1'b1;
				end
				PH_RST1: begin
					res_d.tx_byte    = FL_RST;
					res_d.tx_valid   = 1'b1;
					res_d.frame_last = 1'b1;
				end
				default: res_d.op_done = 1'b1;
			endcase
		end

		res_d.busy_res = (phase_d != PH_IDLE);
	end

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_accept) begin
				phase_q     <= phase_d;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// every field below is loaded on each accepted transaction
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			current_op_q      <= current_op_d;
			flash_address_q   <= flash_address_d;
			bytes_remaining_q <= bytes_remaining_d;
			chunk_remaining_q <= chunk_remaining_d;
			header_index_q    <= header_index_d;
			res_q             <= res_d;
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`SFC_ASSERT_NEXT(a_idle_xchg_quiet, clk, arst_n, (cmd_accept && phase_q == PH_IDLE && cmd.data.mode == MODE_XCHG), (res.valid && !res.data.tx_valid && !res.data.busy_res && !res.data.op_done))
	`SFC_ASSERT_IMPLIES(a_done_not_busy, clk, arst_n, (res.valid && res.data.op_done), (!res.data.busy_res && !res.data.wr_take))
	`SFC_ASSERT_IMPLIES(a_take_in_program, clk, arst_n, (res.valid && res.data.wr_take), (res.data.tx_valid && current_op_q == OP_PROG))
	`SFC_ASSERT_NEXT(a_busy_cmd_dropped, clk, arst_n, (cmd_accept && phase_q != PH_IDLE && cmd.data.mode == MODE_CMD), (res.data.busy_res && !res.data.tx_valid && $stable(current_op_q)))

endmodule

`default_nettype wire
